FILE: hw/rtl/lsmi_pkg.sv
// Shared constants, command and status types for the left-shift modular inverse unit.
package lsmi_pkg;

	localparam int WORD_W        = 16;
	localparam int FIELD_W       = 14;
	localparam int LOOP_LIMIT    = 16 * WORD_W;
	localparam int CNT_W         = $clog2(LOOP_LIMIT + 1);
	localparam int SIZE_W        = $clog2(WORD_W);
	localparam int REM_CNT_W     = $clog2(WORD_W);
	localparam int MODULUS_RESET = 3;

	typedef logic signed [WORD_W-1:0] word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic fix_swap;
		logic fix_sign;
		logic fix_range;
		logic dbl;
		logic rem_init;
		logic rem_step;
		logic finish;
	} lsmi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic invalid;
		logic loop_done;
		logic dbl_done;
		logic rem_last;
	} lsmi_status_t;

endpackage

FILE: hw/rtl/left_shift_modular_inverse_unit.sv
// Top level of the left-shift modular inverse unit: modulus register, controller, datapath.
//
// Computes operand_value^-1 mod p for the odd prime p held in the modulus register, using
// left-shift binary inversion on 16-bit two's complement working values. Raise start with
// an operand while busy is low; the request is taken on that edge and busy stays high until
// the result is out. The result appears on inverse_value and invalid_operand for exactly one
// cycle with done high; the receiver cannot hold it off, so capture it on that edge.
// An operand of zero or above p is flagged with invalid_operand and returns zero; such a
// request leaves the loop at once and goes straight to the result strobe. Otherwise the
// request runs load, phase one (N1 iterations of the shared add/shift unit, roughly two per
// bit of p, capped at 256), the three fix-ups, N2 modular doublings (at most one per bit of
// p, capped at 256), and a bit-serial remainder over 16 bits that brings the result into
// [0, p), then the result strobe. Write modulus_wdata with modulus_we only while busy is low
// and no result is pending; it resets to 3.
module left_shift_modular_inverse_unit import lsmi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               modulus_we,
	input  logic [FIELD_W-1:0] modulus_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [FIELD_W-1:0] operand_value,
	output logic               done,
	output logic [FIELD_W-1:0] inverse_value,
	output logic               invalid_operand
);

	logic [FIELD_W-1:0] modulus_q;
	lsmi_cmd_t          cmd;
	lsmi_status_t       status;

	// Hold the modulus; the user must change it only between requests, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= FIELD_W'(MODULUS_RESET);
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	// Sequence load, phase one, the three fix-ups, doubling, remainder and result strobe.
	lsmi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Working registers u, v, r, s with their shift counters, and the result register.
	lsmi_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.modulus         (modulus_q),
		.operand_value   (operand_value),
		.done            (done),
		.inverse_value   (inverse_value),
		.invalid_operand (invalid_operand)
	);

endmodule

FILE: hw/rtl/lsmi_datapath.sv
// Datapath of the left-shift modular inverse unit: working registers, adders, remainder.
module lsmi_datapath import lsmi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsmi_cmd_t            cmd,
	output lsmi_status_t         status,
	input  logic [FIELD_W-1:0]   modulus,
	input  logic [FIELD_W-1:0]   operand_value,
	output logic                 done,
	output logic [FIELD_W-1:0]   inverse_value,
	output logic                 invalid_operand
);

	word_t                u_q, v_q, r_q, s_q;
	logic [CNT_W-1:0]     cu_q, cv_q, iter_q;
	logic [SIZE_W-1:0]    size_q;
	logic                 inval_q;
	logic [WORD_W-1:0]    mag_q;
	logic                 neg_q;
	logic [FIELD_W-1:0]   rem_q;
	logic [REM_CNT_W-1:0] rcnt_q;
	logic                 done_q;
	logic [FIELD_W-1:0]   inverse_q;
	logic                 invalid_q;

	word_t                p_w;
	logic                 ms_u, ms_v, minus, pm_u, pm_v;
	logic [WORD_W-1:0]    keep;
	word_t                r_dbl;
	logic [FIELD_W:0]     rem_t;
	logic [FIELD_W-1:0]   rem_nxt;
	logic [FIELD_W-1:0]   res;

	function automatic logic [SIZE_W-1:0] bit_len(input logic [FIELD_W-1:0] x);
		logic [SIZE_W-1:0] n;
		n = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (x[i]) n = SIZE_W'(i + 1);
		end
		return n;
	endfunction

	// Match against +-2^c in the word; zero once 2^c falls off the word.
	function automatic logic is_pm(input word_t x, input logic [CNT_W-1:0] c);
		logic [WORD_W-1:0] q;
		q = (c < CNT_W'(WORD_W)) ? (WORD_W'(1) << c[SIZE_W-1:0]) : '0;
		return (x == q) || (x == (~q + WORD_W'(1)));
	endfunction

	function automatic logic may_shift(input word_t x, input logic [SIZE_W-1:0] size);
		logic [WORD_W-1:0] lm;
		logic              hi, nx;
		lm = (WORD_W'(1) << (size - SIZE_W'(1))) - WORD_W'(1);
		hi = x[size];
		nx = x[size - SIZE_W'(1)];
		return (!hi && !nx) || (hi && nx && (|(x & lm)));
	endfunction

	function automatic word_t halve_mod(input word_t x, input word_t p);
		word_t t;
		t = x[0] ? (x + p) : x;
		return {t[WORD_W-1], t[WORD_W-1:1]};
	endfunction

	assign p_w   = word_t'({{(WORD_W - FIELD_W){1'b0}}, modulus});
	assign ms_u  = may_shift(u_q, size_q);
	assign ms_v  = may_shift(v_q, size_q);
	assign minus = (u_q[size_q] == v_q[size_q]);
	assign pm_u  = is_pm(u_q, cu_q);
	assign pm_v  = is_pm(v_q, cv_q);

	// Bits from max(size-2, 0) upward come from v on the swap.
	assign keep = (size_q >= SIZE_W'(2)) ? (~WORD_W'(0) << (size_q - SIZE_W'(2))) : ~WORD_W'(0);

	assign r_dbl   = {r_q[WORD_W-2:0], 1'b0};
	assign rem_t   = {rem_q, mag_q[WORD_W-1]};
	assign rem_nxt = (rem_t >= {1'b0, modulus}) ? FIELD_W'(rem_t - {1'b0, modulus})
	                                            : rem_t[FIELD_W-1:0];
	assign res     = inval_q ? '0 :
	                 !neg_q ? rem_q :
	                 (rem_q != '0) ? (modulus - rem_q) : '0;

	assign status.invalid   = inval_q;
	assign status.loop_done = pm_u || pm_v || (iter_q == CNT_W'(LOOP_LIMIT));
	assign status.dbl_done  = (cv_q == '0);
	assign status.rem_last  = (rcnt_q == REM_CNT_W'(WORD_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inval_q <= (operand_value == '0) || (operand_value > modulus);
			u_q     <= p_w;
			v_q     <= word_t'({{(WORD_W - FIELD_W){1'b0}}, operand_value});
			r_q     <= '0;
			s_q     <= word_t'(1);
			cu_q    <= '0;
			cv_q    <= '0;
			iter_q  <= '0;
			size_q  <= bit_len(modulus);
		end else if (cmd.step) begin
			iter_q <= iter_q + CNT_W'(1);
			if (ms_u) begin
				u_q  <= {u_q[WORD_W-2:0], 1'b0};
				s_q  <= halve_mod(s_q, p_w);
				cu_q <= cu_q + CNT_W'(1);
			end else if (ms_v) begin
				v_q  <= {v_q[WORD_W-2:0], 1'b0};
				r_q  <= halve_mod(r_q, p_w);
				cv_q <= cv_q + CNT_W'(1);
			end else if (cu_q <= cv_q) begin
				u_q <= minus ? (u_q - v_q) : (u_q + v_q);
				r_q <= minus ? (r_q - s_q) : (r_q + s_q);
			end else begin
				v_q <= minus ? (v_q - u_q) : (v_q + u_q);
				s_q <= minus ? (s_q - r_q) : (s_q + r_q);
			end
		end else if (cmd.fix_swap) begin
			if (pm_v) begin
				r_q  <= s_q;
				u_q  <= (u_q & ~keep) | (v_q & keep);
				cv_q <= cu_q;
			end
		end else if (cmd.fix_sign) begin
			if (u_q < 0) begin
				r_q <= (r_q < 0) ? -r_q : (p_w - r_q);
			end
		end else if (cmd.fix_range) begin
			if (r_q < 0) begin
				r_q <= r_q + p_w;
			end
		end else if (cmd.dbl) begin
			r_q  <= (r_dbl >= p_w) ? (r_dbl - p_w) : r_dbl;
			cv_q <= cv_q - CNT_W'(1);
		end
		if (cmd.rem_init) begin
			neg_q  <= r_q[WORD_W-1];
			mag_q  <= r_q[WORD_W-1] ? WORD_W'(-r_q) : WORD_W'(r_q);
			rem_q  <= '0;
			rcnt_q <= '0;
		end else if (cmd.rem_step) begin
			rem_q  <= rem_nxt;
			mag_q  <= {mag_q[WORD_W-2:0], 1'b0};
			rcnt_q <= rcnt_q + REM_CNT_W'(1);
		end
		if (cmd.finish) begin
			inverse_q <= res;
			invalid_q <= inval_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done            = done_q;
	assign inverse_value   = inverse_q;
	assign invalid_operand = invalid_q;

endmodule

FILE: hw/rtl/lsmi_ctrl.sv
// Controller state machine of the left-shift modular inverse unit.
module lsmi_ctrl import lsmi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  lsmi_status_t status,
	output lsmi_cmd_t    cmd,
	output logic         busy
);

	typedef enum logic [2:0] {
		IDLE,
		LOOP,
		FIX_SWAP,
		FIX_SIGN,
		FIX_RANGE,
		DOUBLE,
		REMAIN,
		FINISH
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= LOOP;
						busy_q  <= 1'b1;
					end
				end
				LOOP: begin
					if (status.invalid) state_q <= FINISH;
					else if (status.loop_done) state_q <= FIX_SWAP;
				end
				FIX_SWAP:  state_q <= FIX_SIGN;
				FIX_SIGN:  state_q <= FIX_RANGE;
				FIX_RANGE: state_q <= DOUBLE;
				DOUBLE: begin
					if (status.dbl_done) state_q <= REMAIN;
				end
				REMAIN: begin
					if (status.rem_last) state_q <= FINISH;
				end
				FINISH: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == IDLE) && start;
		cmd.step      = (state_q == LOOP) && !status.invalid && !status.loop_done;
		cmd.fix_swap  = (state_q == FIX_SWAP);
		cmd.fix_sign  = (state_q == FIX_SIGN);
		cmd.fix_range = (state_q == FIX_RANGE);
		cmd.dbl       = (state_q == DOUBLE) && !status.dbl_done;
		cmd.rem_init  = (state_q == DOUBLE) && status.dbl_done;
		cmd.rem_step  = (state_q == REMAIN);
		cmd.finish    = (state_q == FINISH);
	end

	assign busy = busy_q;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the left-shift modular inverse unit.
`timescale 1ns / 100ps

module tb_top import lsmi_pkg::*;;

	localparam int FIELD_MAX     = (1 << FIELD_W) - 1;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int MAX_REPORTS   = 40;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 160;
	localparam int MAX_GAP       = 16;
	localparam int LARGEST_PRIME = 16381;

	logic               clk;
	logic               arst_n;
	logic               modulus_we;
	logic [FIELD_W-1:0] modulus_wdata;
	logic               start;
	logic               busy;
	logic [FIELD_W-1:0] operand_value;
	logic               done;
	logic [FIELD_W-1:0] inverse_value;
	logic               invalid_operand;

	int unsigned cycle_count = 0;
	int unsigned modulus_writes;

	// One expected result, with the request that caused it kept for messages.
	typedef struct {
		logic [FIELD_W-1:0] operand;
		logic [FIELD_W-1:0] modulus;
		logic [FIELD_W-1:0] inverse;
		logic               invalid;
	} inverse_expect_t;

	class inverse_scoreboard;
		logic [FIELD_W-1:0] modulus;
		inverse_expect_t    expected_inverses[$];
		int unsigned        request_count;
		int unsigned        invalid_count;
		int unsigned        checked_count;
		int unsigned        mismatches;

		function new();
			modulus = FIELD_W'(MODULUS_RESET);
		endfunction

		// Truncate to the working word and sign-extend back.
		function longint wrap_word(longint x);
			word_t w;
			w = x[WORD_W-1:0];
			return w;
		endfunction

		function bit bit_of(longint x, int b);
			if (b < 0) b = 0;
			if (b > 63) b = 63;
			return x[b];
		endfunction

		// True when x is plus or minus the wrapped power 2^c (zero once it wraps out).
		function bit at_power(longint x, int c);
			longint q;
			q = (c < 0 || c >= WORD_W) ? 0 : wrap_word(64'sd1 << c);
			return x == q || x == -q;
		endfunction

		// A left shift keeps the value inside the window.
		function bit can_shift(longint x, int size);
			bit hi, nx, low;
			int i;
			hi = bit_of(x, size);
			nx = bit_of(x, size - 1);
			low = 1'b0;
			for (i = 0; i <= size - 2 && i <= 63; i++)
				low |= x[i];
			return (!hi && !nx) || (hi && nx && low);
		endfunction

		function longint halve_mod(longint x, longint p);
			if (!x[0])
				return x >>> 1;
			return wrap_word(x + p) >>> 1;
		endfunction

		function logic [FIELD_W-1:0] predict_inverse(longint a, longint p);
			longint u, v, r, s, big;
			int cu, cv, size, iter, k, i;
			logic [63:0] keep;
			bit minus;
			u = p;
			v = a;
			r = 0;
			s = 1;
			cu = 0;
			cv = 0;
			size = 0;
			iter = 0;
			big = (v < u) ? u : v;
			while (big > 0 && size < 64) begin
				size++;
				big = big >>> 1;
			end
			// Phase one: normalize by shifts, else combine by sign, until a power is hit.
			while (!at_power(u, cu) && !at_power(v, cv) && iter < LOOP_LIMIT) begin
				iter++;
				if (can_shift(u, size)) begin
					u = wrap_word(u << 1);
					s = halve_mod(s, p);
					cu++;
				end else if (can_shift(v, size)) begin
					v = wrap_word(v << 1);
					r = halve_mod(r, p);
					cv++;
				end else begin
					minus = bit_of(u, size) == bit_of(v, size);
					if (cu <= cv) begin
						u = wrap_word(minus ? u - v : u + v);
						r = wrap_word(minus ? r - s : r + s);
					end else begin
						v = wrap_word(minus ? v - u : v + u);
						s = wrap_word(minus ? s - r : s + r);
					end
				end
			end
			// Swap in the u side when v finished first; splice high bits of v into u.
			if (at_power(v, cv)) begin
				r = s;
				k = (size - 2 < 0) ? 0 : size - 2;
				keep = ~((64'd1 << k) - 64'd1);
				u = wrap_word((u & ~keep) | (v & keep));
				cv = cu;
			end
			if (u < 0)
				r = (r < 0) ? wrap_word(-r) : wrap_word(p - r);
			if (r < 0)
				r = wrap_word(r + p);
			// Phase two: modular doublings.
			for (i = 1; i < cv + 1; i++) begin
				r = wrap_word(r << 1);
				if (r >= p)
					r = wrap_word(r - p);
			end
			r = r % p;
			if (r < 0)
				r = r + p;
			return r[FIELD_W-1:0];
		endfunction

		function void note_request(logic [FIELD_W-1:0] a);
			inverse_expect_t e;
			longint av, pv;
			av = a;
			pv = modulus;
			e.operand = a;
			e.modulus = modulus;
			if (av < 1 || av > pv) begin
				e.inverse = '0;
				e.invalid = 1'b1;
				invalid_count++;
			end else begin
				e.inverse = predict_inverse(av, pv);
				e.invalid = 1'b0;
			end
			expected_inverses.push_back(e);
			request_count++;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0t] MISMATCH %s", $time, what);
		endtask

		task check_result(logic [FIELD_W-1:0] inverse, logic invalid);
			inverse_expect_t want;
			if (expected_inverses.size() == 0) begin
				report_mismatch($sformatf("unexpected result inverse=%0d invalid=%0b",
					inverse, invalid));
				return;
			end
			want = expected_inverses.pop_front();
			checked_count++;
			if (inverse !== want.inverse)
				report_mismatch($sformatf("a=%0d p=%0d inverse got %0d want %0d",
					want.operand, want.modulus, inverse, want.inverse));
			if (invalid !== want.invalid)
				report_mismatch($sformatf("a=%0d p=%0d invalid got %0b want %0b",
					want.operand, want.modulus, invalid, want.invalid));
		endtask
	endclass

	inverse_scoreboard sb = new();

	left_shift_modular_inverse_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.modulus_we     (modulus_we),
		.modulus_wdata  (modulus_wdata),
		.start          (start),
		.busy           (busy),
		.operand_value  (operand_value),
		.done           (done),
		.inverse_value  (inverse_value),
		.invalid_operand(invalid_operand)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: end the run if it stalls.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d results still expected", cycle_count,
			sb.expected_inverses.size());
		$display("Some tests failed");
		$finish;
	end

	// Capture each result on the edge that ends its strobe cycle; it cannot be held.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(inverse_value, invalid_operand);
	end

	// Enter and leave at a falling edge. Idle for gap cycles, then hold the request
	// until the block takes it; leave start high so a zero gap gives back-to-back requests.
	task automatic issue_request(input logic [FIELD_W-1:0] a, input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		operand_value <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(a);
		@(negedge clk);
	endtask

	// Drop start and wait until every expected result is back and the block settles.
	task automatic wait_until_idle();
		start <= 1'b0;
		while (sb.expected_inverses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_modulus(input logic [FIELD_W-1:0] value);
		wait_until_idle();
		modulus_we <= 1'b1;
		modulus_wdata <= value;
		@(posedge clk);
		sb.modulus = value;
		modulus_writes++;
		@(negedge clk);
		modulus_we <= 1'b0;
	endtask

	// Directed cases as (modulus, operand); the first group runs on the reset modulus.
	int unsigned directed_pairs[23][2] = '{
		'{3, 0}, '{3, 1}, '{3, 2}, '{3, 3}, '{3, 4},
		'{LARGEST_PRIME, 1}, '{LARGEST_PRIME, 2}, '{LARGEST_PRIME, LARGEST_PRIME - 1},
		'{LARGEST_PRIME, LARGEST_PRIME}, '{LARGEST_PRIME, LARGEST_PRIME + 1},
		'{LARGEST_PRIME, FIELD_MAX}, '{LARGEST_PRIME, 8191}, '{LARGEST_PRIME, 'h2AAA},
		'{LARGEST_PRIME, 'h1555},
		'{0, 1}, '{0, FIELD_MAX},
		'{1, 1},
		'{2, 1}, '{2, 2},
		'{FIELD_MAX, FIELD_MAX}, '{FIELD_MAX, 3}, '{FIELD_MAX, 2},
		'{9, 3}
	};

	initial begin
		int unsigned p, a, cand, bound, gap, pick, pause_at;
		bit composite;
		int d;

		arst_n = 1'b0;
		start = 1'b0;
		modulus_we = 1'b0;
		modulus_wdata = '0;
		operand_value = '0;
		modulus_writes = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: operand extremes, operand equal to and above the modulus,
		// zero, one and two as modulus, composite moduli that run the loop out.
		foreach (directed_pairs[i]) begin
			if (directed_pairs[i][0] != sb.modulus)
				write_modulus(FIELD_W'(directed_pairs[i][0]));
			issue_request(FIELD_W'(directed_pairs[i][1]), $urandom_range(0, MAX_GAP));
		end

		// Random: one modulus per phase, mostly primes, with the extremes and a wild one.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: p = LARGEST_PRIME;
				1: p = 3;
				2: p = FIELD_MAX;
				3: p = $urandom_range(0, FIELD_MAX);
				default: begin
					bound = (phase == 4) ? 127 : FIELD_MAX;
					cand = $urandom_range(3, bound) | 1;
					do begin
						composite = 1'b0;
						for (d = 3; d * d <= cand; d += 2)
							if (cand % d == 0)
								composite = 1'b1;
						if (composite)
							cand = (cand + 2 > bound) ? 3 : cand + 2;
					end while (composite);
					p = cand;
				end
			endcase
			write_modulus(FIELD_W'(p));
			pause_at = $urandom_range(10, PHASE_ITEMS - 10);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Let the pipeline run dry once per phase.
				if (n == pause_at)
					wait_until_idle();
				pick = $urandom_range(0, 99);
				if (p == 0 || pick >= 85)
					a = $urandom_range(0, FIELD_MAX);
				else if (pick < 75)
					a = $urandom_range(1, p);
				else if (pick < 80)
					a = p;
				else
					a = pick[0] ? 1 : p - 1;
				// Alternate stretches of back-to-back requests with random idling.
				gap = ((n / 24) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
				issue_request(a[FIELD_W-1:0], gap);
			end
		end

		wait_until_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d out of range) over %0d modulus writes, %0d results checked",
			sb.request_count, sb.invalid_count, modulus_writes, sb.checked_count);
		$display("Moduli covered reset value, extremes, small and large primes, composites; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
